@@ rtl/rmmpc_pkg.sv @@
// Shared constants, types and helpers for the rook-move minimum path cost block.
package rmmpc_pkg;

    localparam int MAX_GRID = 64;
    localparam int IDX_W    = $clog2(MAX_GRID);
    localparam int SIZE_W   = 7;
    localparam int COST_W   = 8;
    localparam int PATH_W   = 16;

    localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(8);
    localparam logic [PATH_W-1:0] PATH_MAX   = {PATH_W{1'b1}};

    // One result beat
    typedef struct packed {
        logic [PATH_W-1:0] path_cost;
        logic              saturated;
        logic              last_cell;
    } result_t;

    // Grid size in use: zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] n;
        n = size;
        if (n == '0)
        begin
            n = SIZE_W'(1);
        end
        else if (n > SIZE_W'(MAX_GRID))
        begin
            n = SIZE_W'(MAX_GRID);
        end
        return n;
    endfunction

endpackage

@@ rtl/rmmpc_cell.sv @@
// One column cell: holds the best path cost of one column as it travels down the chain.
module rmmpc_cell (
    input  logic                            clk,
    input  logic                            shift,
    input  logic                            tail,
    input  logic [rmmpc_pkg::PATH_W-1:0]    new_cost,
    input  logic [rmmpc_pkg::PATH_W-1:0]    neighbor_cost,
    output logic [rmmpc_pkg::PATH_W-1:0]    cost
);

    logic [rmmpc_pkg::PATH_W-1:0] cost_reg;
    logic [rmmpc_pkg::PATH_W-1:0] cost_next;

    // On shift the tail takes the fresh column minimum, others their neighbor's value
    always_comb
    begin
        cost_next = cost_reg;
        if (shift)
        begin
            cost_next = tail ? new_cost : neighbor_cost;
        end
    end

    always_ff @(posedge clk)
    begin
        cost_reg <= cost_next;
    end

    assign cost = cost_reg;

endmodule

@@ rtl/rmmpc_skid.sv @@
// Output register with a one-beat skid stage so the input side can hand over one more beat while a result waits.
module rmmpc_skid (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rmmpc_pkg::result_t      push_data,
    output logic                    full,
    output logic                    out_valid,
    input  logic                    out_stall,
    output rmmpc_pkg::result_t      out_data
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    rmmpc_pkg::result_t out_data_reg;
    rmmpc_pkg::result_t out_data_next;
    rmmpc_pkg::result_t skid_data_reg;
    rmmpc_pkg::result_t skid_data_next;

    // Fill output first, park in skid only when output is held
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !out_stall)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : push_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A parked beat always has an occupied output ahead of it
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output is empty");

    // Skid only fills when the output was held
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!skid_valid_reg && push && !(out_valid_reg && out_stall)) |=> !skid_valid_reg)
        else $error("skid filled although output could take the beat");

    // Never accept into a full skid
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("beat pushed while skid full");

endmodule

@@ rtl/rook_move_min_path_cost.sv @@
// Top level: streaming minimum path cost over a square grid with right/down rook moves.
//
// Cells arrive in raster order, one beat per cell, and each produces exactly one
// result beat carrying the least path cost to that cell (saturated at 65535, with a
// flag) and a last_cell mark on the bottom-right cell. One cell is taken every clock
// cycle unless in_stall is up (full skid or size write); results are registered, or
// parked in the skid. Per-cell work: compares against the row and column minima,
// one add and one saturate. Column minima travel through a chain of 64 cells that
// shifts once per accepted cell, so the minimum for a column returns to the head
// exactly one grid row later. Writing grid_size (through cfg_valid/cfg_ready, always
// ready) restarts the grid at the top-left cell; cell beats are stalled while a
// write is presented. Write it only while no results are outstanding.
module rook_move_min_path_cost (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rmmpc_pkg::SIZE_W-1:0]        grid_size,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rmmpc_pkg::COST_W-1:0]        cell_cost,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rmmpc_pkg::PATH_W-1:0]        path_cost,
    output logic                                saturated,
    output logic                                last_cell
);

    localparam int N  = rmmpc_pkg::MAX_GRID;
    localparam int IW = rmmpc_pkg::IDX_W;
    localparam int SW = rmmpc_pkg::SIZE_W;
    localparam int PW = rmmpc_pkg::PATH_W;

    logic [SW-1:0] grid_size_reg;
    logic [SW-1:0] grid_size_next;
    logic [IW-1:0] row_index_reg;
    logic [IW-1:0] row_index_next;
    logic [IW-1:0] col_index_reg;
    logic [IW-1:0] col_index_next;
    logic [PW-1:0] row_best_reg;
    logic [PW-1:0] row_best_next;

    logic          cfg_write;
    logic          accept;
    logic          skid_full;
    logic [SW-1:0] n_active;
    logic [IW-1:0] n_m1;
    logic [IW-1:0] i_cur;
    logic [IW-1:0] j_cur;
    logic          first;
    logic [PW-1:0] best;
    logic [PW:0]   sum;
    logic [PW-1:0] total;
    logic          clip;
    logic [PW-1:0] col_new;
    logic          is_last;

    logic [PW-1:0] chain_cost [N];

    rmmpc_pkg::result_t result;
    rmmpc_pkg::result_t out_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign in_stall  = skid_full || cfg_write;
    assign accept    = in_valid && !in_stall;

    assign n_active = rmmpc_pkg::clamp_size(grid_size_reg);
    assign n_m1     = IW'(n_active - SW'(1));

    // Position, path cost and running minima for the current cell
    always_comb
    begin
        i_cur = row_index_reg;
        j_cur = col_index_reg;
        if ({1'b0, row_index_reg} >= n_active || {1'b0, col_index_reg} >= n_active)
        begin
            i_cur = '0;
            j_cur = '0;
        end
        first = (i_cur == '0) && (j_cur == '0);

        best = rmmpc_pkg::PATH_MAX;
        if (j_cur != '0 && row_best_reg < best)
        begin
            best = row_best_reg;
        end
        if (i_cur != '0 && chain_cost[0] < best)
        begin
            best = chain_cost[0];
        end
        sum = {1'b0, best} + (PW+1)'(cell_cost);

        if (first)
        begin
            total = PW'(cell_cost);
            clip  = 1'b0;
        end
        else
        begin
            clip  = sum[PW];
            total = clip ? rmmpc_pkg::PATH_MAX : sum[PW-1:0];
        end

        col_new = (i_cur == '0 || total < chain_cost[0]) ? total : chain_cost[0];
        is_last = (i_cur == n_m1) && (j_cur == n_m1);
    end

    // Control state update
    always_comb
    begin
        grid_size_next = grid_size_reg;
        row_index_next = row_index_reg;
        col_index_next = col_index_reg;
        row_best_next  = row_best_reg;
        if (cfg_write)
        begin
            grid_size_next = grid_size;
            row_index_next = '0;
            col_index_next = '0;
            row_best_next  = '0;
        end
        else if (accept)
        begin
            if (j_cur == '0 || total < row_best_reg)
            begin
                row_best_next = total;
            end
            if (j_cur == n_m1)
            begin
                col_index_next = '0;
                row_index_next = (i_cur == n_m1) ? '0 : i_cur + IW'(1);
            end
            else
            begin
                col_index_next = j_cur + IW'(1);
                row_index_next = i_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= rmmpc_pkg::GRID_RESET;
            row_index_reg <= '0;
            col_index_reg <= '0;
            row_best_reg  <= '0;
        end
        else
        begin
            grid_size_reg <= grid_size_next;
            row_index_reg <= row_index_next;
            col_index_reg <= col_index_next;
            row_best_reg  <= row_best_next;
        end
    end

    // Column chain: cell n-1 takes the new minimum, head cell feeds the next row
    for (genvar k = 0; k < N; k++)
    begin : g_col
        logic [PW-1:0] neighbor;
        if (k == N - 1)
        begin : g_end
            assign neighbor = col_new;
        end
        else
        begin : g_mid
            assign neighbor = chain_cost[k+1];
        end

        rmmpc_cell u_cell (
            .clk           (clk),
            .shift         (accept && !cfg_write),
            .tail          (n_m1 == IW'(k)),
            .new_cost      (col_new),
            .neighbor_cost (neighbor),
            .cost          (chain_cost[k])
        );
    end

    assign result.path_cost = total;
    assign result.saturated = clip;
    assign result.last_cell = is_last;

    rmmpc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && !cfg_write),
        .push_data (result),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign path_cost = out_data.path_cost;
    assign saturated = out_data.saturated;
    assign last_cell = out_data.last_cell;

    // Clipped results sit at the top of the range
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (path_cost == rmmpc_pkg::PATH_MAX))
        else $error("saturated result below maximum");

    // The last cell wraps the position back to the top-left
    a_last_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_write && is_last) |=> (row_index_reg == '0 && col_index_reg == '0))
        else $error("position did not wrap after last cell");

    // Position stays inside the active grid
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, row_index_reg} < n_active) && ({1'b0, col_index_reg} < n_active))
        else $error("grid position out of range");

    // A configuration write restarts the grid
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (row_index_reg == '0 && col_index_reg == '0 && row_best_reg == '0))
        else $error("grid not restarted after configuration write");

endmodule

@@ tb/path_cost_checker.sv @@
// Checker for the rook-move minimum path cost block: predicts every result beat and compares it.
`timescale 1ns / 1ps

module path_cost_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [rmmpc_pkg::SIZE_W-1:0] grid_size,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [rmmpc_pkg::COST_W-1:0] cell_cost,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [rmmpc_pkg::PATH_W-1:0] path_cost,
    input  logic                         saturated,
    input  logic                         last_cell,
    output int                           pending,
    output int                           mismatch_count
);

    localparam int SIZE_W   = rmmpc_pkg::SIZE_W;
    localparam int COST_W   = rmmpc_pkg::COST_W;
    localparam int PATH_W   = rmmpc_pkg::PATH_W;
    localparam int MAX_GRID = rmmpc_pkg::MAX_GRID;

    // Predicted result beats, oldest first
    rmmpc_pkg::result_t expected_costs[$];
    rmmpc_pkg::result_t want;

    // Predictor copy of the block state
    logic [SIZE_W-1:0] size_reg;
    logic [PATH_W-1:0] column_best [MAX_GRID];
    logic [PATH_W-1:0] row_best;
    int unsigned       row_pos;
    int unsigned       col_pos;
    int                fails;

    // Rows and columns in use for a given register value
    function automatic int unsigned grid_span(input logic [SIZE_W-1:0] size);
        if (size == '0)
        begin
            return 1;
        end
        if (int'(size) > MAX_GRID)
        begin
            return MAX_GRID;
        end
        return int'(size);
    endfunction

    // Least cost to the next cell: own cost plus the better of row and column minima
    task automatic predict_path_cost(input logic [COST_W-1:0] cost);
        int unsigned        n;
        int unsigned        i;
        int unsigned        j;
        int unsigned        best;
        int unsigned        total;
        rmmpc_pkg::result_t res;
        n   = grid_span(size_reg);
        i   = row_pos;
        j   = col_pos;
        res = '0;
        if (i >= n || j >= n)
        begin
            i = 0;
            j = 0;
        end
        if (i == 0 && j == 0)
        begin
            total = cost;
        end
        else
        begin
            best = rmmpc_pkg::PATH_MAX;
            if (j > 0 && row_best < best)
            begin
                best = row_best;
            end
            if (i > 0 && column_best[j] < best)
            begin
                best = column_best[j];
            end
            total = best + cost;
            if (total > rmmpc_pkg::PATH_MAX)
            begin
                total         = rmmpc_pkg::PATH_MAX;
                res.saturated = 1'b1;
            end
        end
        // Running minima; the first cell of a row or column seeds them
        if (j == 0 || total < row_best)
        begin
            row_best = PATH_W'(total);
        end
        if (i == 0 || total < column_best[j])
        begin
            column_best[j] = PATH_W'(total);
        end
        res.path_cost = PATH_W'(total);
        res.last_cell = (i == n - 1 && j == n - 1);
        // Advance in raster order, wrapping to a new grid after the last cell
        j++;
        if (j >= n)
        begin
            j = 0;
            i++;
            if (i >= n)
            begin
                i = 0;
            end
        end
        row_pos = i;
        col_pos = j;
        expected_costs.push_back(res);
    endtask

    // Watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_costs.delete();
            size_reg       = rmmpc_pkg::GRID_RESET;
            row_best       = '0;
            row_pos        = 0;
            col_pos        = 0;
            fails          = 0;
            pending        <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            // Result beat against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_costs.size() == 0)
                begin
                    if (fails < 10)
                    begin
                        $display("%0t: unexpected beat: cost %0d sat %0b last %0b",
                                 $realtime, path_cost, saturated, last_cell);
                    end
                    fails++;
                end
                else
                begin
                    want = expected_costs.pop_front();
                    if (want.path_cost !== path_cost || want.saturated !== saturated ||
                        want.last_cell !== last_cell)
                    begin
                        if (fails < 10)
                        begin
                            $display("%0t: exp cost %0d sat %0b last %0b, got %0d %0b %0b",
                                     $realtime, want.path_cost, want.saturated,
                                     want.last_cell, path_cost, saturated, last_cell);
                        end
                        fails++;
                    end
                end
            end
            // Size write restarts the grid
            if (cfg_valid && cfg_ready)
            begin
                size_reg = grid_size;
                row_best = '0;
                row_pos  = 0;
                col_pos  = 0;
            end
            // Cell beat
            if (in_valid && !in_stall)
            begin
                predict_path_cost(cell_cost);
            end
            pending        <= expected_costs.size();
            mismatch_count <= fails;
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the rook-move minimum path cost testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int SIZE_W   = rmmpc_pkg::SIZE_W;
    localparam int COST_W   = rmmpc_pkg::COST_W;
    localparam int PATH_W   = rmmpc_pkg::PATH_W;
    localparam int MAX_GRID = rmmpc_pkg::MAX_GRID;

    localparam int RANDOM_CELLS   = 1350;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_WAIT       = 13;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] grid_size = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [COST_W-1:0] cell_cost = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [PATH_W-1:0] path_cost;
    logic              saturated;
    logic              last_cell;

    int pending;
    int mismatch_count;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;

    rook_move_min_path_cost i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .grid_size (grid_size),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cell_cost (cell_cost),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .path_cost (path_cost),
        .saturated (saturated),
        .last_cell (last_cell)
    );

    path_cost_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .grid_size      (grid_size),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cell_cost      (cell_cost),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .path_cost      (path_cost),
        .saturated      (saturated),
        .last_cell      (last_cell),
        .pending        (pending),
        .mismatch_count (mismatch_count)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cost with the extremes weighted up
    function automatic logic [COST_W-1:0] pick_cost();
        unique case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COST_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One cell beat after a random gap; returns at the accepting edge
    task automatic send_cell(input logic [COST_W-1:0] cost);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cell_cost <= cost;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Size write, only with the block idle
    task automatic load_size(input logic [SIZE_W-1:0] size);
        wait_drained();
        cfg_valid <= 1'b1;
        grid_size <= size;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall per beat
    initial
    begin
        int hold;
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rook_move_min_path_cost");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and verdict
    initial
    begin
        int                cells_left;
        int                count;
        int                pause_at;
        int                span;
        int                pick;
        logic [SIZE_W-1:0] size;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset grid size
        send_cell(8'd3);
        send_cell(8'd4);
        // One-cell grids, and zero acting as one
        load_size(SIZE_W'(1));
        send_cell(8'd255);
        send_cell(8'd0);
        load_size(SIZE_W'(0));
        send_cell(8'd128);
        // Two by two, twice to cross the grid wrap
        load_size(SIZE_W'(2));
        send_cell(8'd0);
        send_cell(8'd255);
        send_cell(8'd255);
        send_cell(8'd0);
        send_cell(8'd1);
        send_cell(8'd2);
        send_cell(8'd3);
        send_cell(8'd4);
        // Three by three, row and column minima both matter
        load_size(SIZE_W'(3));
        send_cell(8'd5);
        send_cell(8'd0);
        send_cell(8'd255);
        send_cell(8'd255);
        send_cell(8'd1);
        send_cell(8'd0);
        send_cell(8'd0);
        send_cell(8'd255);
        send_cell(8'd7);
        // Oversize acts as the maximum; rewrite mid-grid restarts
        load_size(SIZE_W'(127));
        send_cell(8'd255);
        send_cell(8'd255);
        send_cell(8'd0);
        load_size(SIZE_W'(MAX_GRID));
        send_cell(8'd9);
        send_cell(8'd200);

        // Random phases: mostly whole small grids, some partial, a few at full size
        cells_left = RANDOM_CELLS;
        while (cells_left > 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                size  = SIZE_W'($urandom_range(MAX_GRID, 127));
                span  = MAX_GRID;
                count = $urandom_range(MAX_GRID, 3 * MAX_GRID);
            end
            else
            begin
                size  = (pick == 1) ? SIZE_W'($urandom_range(0, 1))
                                    : SIZE_W'($urandom_range(2, 9));
                span  = (size == '0) ? 1 : size;
                count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * span * span)
                                                    : span * span * $urandom_range(1, 3);
            end
            pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1;
            load_size(size);
            no_idle = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < count; k++)
            begin
                if (k == pause_at)
                begin
                    wait_drained();
                end
                send_cell(pick_cost());
            end
            no_idle = 1'b0;
            cells_left -= count;
        end

        // Drain and let any stray beat show up
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS rook_move_min_path_cost");
        end
        else
        begin
            $display("FAIL rook_move_min_path_cost");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rmmpc_pkg.sv
rtl/rmmpc_cell.sv
rtl/rmmpc_skid.sv
rtl/rook_move_min_path_cost.sv
tb/path_cost_checker.sv
tb/tb_top.sv
